// File: rtl/tsa_pkg.sv
// Shared types, codes and helpers for the transaction slot allocator.
// No dependencies; imported by tsa_ctrl, tsa_datapath and the top level.
`default_nettype none

package tsa_pkg;

	// request modes
	localparam logic MODE_ALLOC  = 1'b0;
	localparam logic MODE_LOOKUP = 1'b1;

	// configuration register indexes
	localparam logic CFG_RETRY_LIMIT     = 1'b0;
	localparam logic CFG_REQUEST_TIMEOUT = 1'b1;

	// reset values of the configuration registers
	localparam logic [7:0]  RETRY_LIMIT_RST     = 8'd3;
	localparam logic [15:0] REQUEST_TIMEOUT_RST = 16'd3000;

	// first invoke ID handed out; zero is never used
	localparam logic [7:0] ID_FIRST = 8'd1;

	// one slot table entry
	typedef struct packed {
		logic [15:0] timer;
		logic [7:0]  retries;
		logic [7:0]  id;
	} slot_entry_t;

	// controller to datapath
	typedef struct packed {
		logic load;     // capture a new request
		logic issue;    // read the slot at the scan pointer and advance
		logic capture;  // lookup matched: keep the slot number
		logic bump;     // candidate ID taken: try the next and rescan
		logic emit;     // load the result register, commit an allocation
	} tsa_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic mode;     // mode of the request in progress
		logic full;     // no idle slot
		logic scan_end; // every busy slot read has been issued
		logic rd_vld;   // a slot read is in flight
		logic match;    // slot read back holds the key
		logic out_free; // result register can take a result
	} tsa_status_t;

	// rolling ID increment that skips zero
	function automatic logic [7:0] bump_id(input logic [7:0] id);
		logic [7:0] nxt;
		nxt = id + 8'd1;
		return (nxt == 8'd0) ? ID_FIRST : nxt;
	endfunction

endpackage

`default_nettype wire

// File: rtl/tsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/tsa_ctrl.sv
// Sequencer for the transaction slot allocator: request intake, slot scan, result.
// Depends on tsa_pkg; drives tsa_datapath through tsa_cmd_t.
`default_nettype none

module tsa_ctrl
	import tsa_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire tsa_status_t status,
	output tsa_cmd_t         cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;

	logic alloc_full;

	assign alloc_full = (status.mode == MODE_ALLOC) && status.full;
	assign req_stall  = (state_q != S_IDLE);

	// next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				if (alloc_full) begin
					state_d = S_DONE;
				end else if (status.match) begin
					if (status.mode == MODE_LOOKUP) begin
						cmd.capture = 1'b1;
						state_d     = S_DONE;
					end else begin
						// candidate is held by a busy slot
						cmd.bump = 1'b1;
					end
				end else if (status.scan_end && !status.rd_vld) begin
					state_d = S_DONE;
				end else if (!status.scan_end) begin
					cmd.issue = 1'b1;
				end
			end
			S_DONE: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/tsa_datapath.sv
// Datapath of the transaction slot allocator: slot table, ID counter, scan, result register.
// Depends on tsa_pkg and tsa_ram; controlled by tsa_ctrl.
`default_nettype none

module tsa_datapath
	import tsa_pkg::*;
#(
	parameter int SLOTS = 8,
	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
	localparam int CW = $clog2(SLOTS + 1)
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request payload
	input  wire logic        mode,
	input  wire logic [7:0]  invoke_id,
	// configuration writes
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data,
	// control
	input  wire tsa_cmd_t    cmd,
	output tsa_status_t      status,
	// result channel
	input  wire logic        res_stall,
	output logic             res_valid,
	output logic [7:0]       assigned_id,
	output logic [2:0]       slot_index,
	output logic             hit,
	output logic [3:0]       idle_count,
	output logic             available
);

	localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

	// configuration
	logic [7:0]  retry_q;
	logic [15:0] timeout_q;

	// table state
	logic [CW-1:0] fill_q;     // busy slots form the prefix below fill_q
	logic [7:0]    next_id_q;

	// request in progress
	logic          mode_q;
	logic [7:0]    want_q;
	logic [7:0]    cand_q;
	logic [CW-1:0] idx_q;
	logic          rd_vld_s1;
	logic [AW-1:0] idx_s1;
	logic          found_q;
	logic [AW-1:0] slot_q;

	// result register
	logic          res_valid_q;
	logic [7:0]    res_id_q;
	logic [2:0]    res_slot_q;
	logic          res_hit_q;
	logic [3:0]    res_idle_q;
	logic          res_avail_q;

	// slot table
	logic                     ram_we;
	logic [$bits(slot_entry_t)-1:0] ram_wdata;
	logic [$bits(slot_entry_t)-1:0] ram_rdata;
	slot_entry_t              rd_entry;

	logic          full;
	logic          commit;
	logic [7:0]    key;
	logic          res_hit_d;
	logic [AW-1:0] res_slot_d;
	logic [CW-1:0] idle_d;
	logic [CW+3:0] idle_x;
	logic [AW+2:0] slot_x;

	assign full     = (fill_q == SLOTS_C);
	assign commit   = cmd.emit && (mode_q == MODE_ALLOC) && !full;
	assign key      = (mode_q == MODE_LOOKUP) ? want_q : cand_q;
	assign rd_entry = slot_entry_t'(ram_rdata);

	assign ram_we    = commit;
	assign ram_wdata = slot_entry_t'{timer: timeout_q, retries: retry_q, id: cand_q};

	tsa_ram #(
		.WIDTH($bits(slot_entry_t)),
		.DEPTH(SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(fill_q[AW-1:0]),
		.wdata(ram_wdata),
		.re   (cmd.issue),
		.raddr(idx_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	// status back to the controller
	always_comb begin
		status.mode     = mode_q;
		status.full     = full;
		status.scan_end = (idx_q == fill_q);
		status.rd_vld   = rd_vld_s1;
		status.match    = rd_vld_s1 && (rd_entry.id == key);
		status.out_free = !res_valid_q || !res_stall;
	end

	// result fields for the request in progress
	always_comb begin
		if (mode_q == MODE_ALLOC) begin
			res_hit_d  = !full;
			res_slot_d = full ? '0 : fill_q[AW-1:0];
		end else begin
			res_hit_d  = found_q;
			res_slot_d = found_q ? slot_q : '0;
		end
		idle_d = SLOTS_C - fill_q - CW'(commit);
		idle_x = {4'b0000, idle_d};
		slot_x = {3'b000, res_slot_d};
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_q   <= RETRY_LIMIT_RST;
			timeout_q <= REQUEST_TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RETRY_LIMIT:     retry_q   <= cfg_data[7:0];
				CFG_REQUEST_TIMEOUT: timeout_q <= cfg_data;
				default:             retry_q   <= retry_q;
			endcase
		end
	end

	// table state, scan control, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			next_id_q   <= ID_FIRST;
			idx_q       <= '0;
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.issue;
			if (cmd.load || cmd.bump) begin
				idx_q <= '0;
			end else if (cmd.issue) begin
				idx_q <= idx_q + CW'(1);
			end
			if (cmd.load) begin
				found_q <= 1'b0;
			end else if (cmd.capture) begin
				found_q <= 1'b1;
			end
			if (commit) begin
				fill_q    <= fill_q + CW'(1);
				next_id_q <= bump_id(cand_q);
			end
			if (cmd.emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			want_q <= invoke_id;
			cand_q <= (next_id_q == 8'd0) ? ID_FIRST : next_id_q;
		end else if (cmd.bump) begin
			cand_q <= bump_id(cand_q);
		end
		if (cmd.issue) begin
			idx_s1 <= idx_q[AW-1:0];
		end
		if (cmd.capture) begin
			slot_q <= idx_s1;
		end
		if (cmd.emit) begin
			res_id_q    <= commit ? cand_q : 8'd0;
			res_slot_q  <= slot_x[2:0];
			res_hit_q   <= res_hit_d;
			res_idle_q  <= (32'(idle_d) > 32'd15) ? 4'd15 : idle_x[3:0];
			res_avail_q <= (idle_d != '0);
		end
	end

	assign res_valid   = res_valid_q;
	assign assigned_id = res_id_q;
	assign slot_index  = res_slot_q;
	assign hit         = res_hit_q;
	assign idle_count  = res_idle_q;
	assign available   = res_avail_q;

endmodule

`default_nettype wire

// File: rtl/transaction_slot_allocator.sv
// Top level of the transaction slot allocator: controller, datapath and config port.
// Depends on tsa_pkg, tsa_ctrl, tsa_datapath and tsa_ram.
//
// Allocates invoke IDs to a table of SLOTS transaction slots and looks up which busy slot
// holds a given ID. Requests are taken one at a time: after acceptance the block scans the
// busy slots, reading one stored slot ID per cycle from the slot table RAM and restarting
// when an allocation's candidate ID is already held; an allocation with no idle slot or a
// lookup on an empty table reads no slot, and a lookup stops at its first hit. A finished
// result waits while the previous one is still stalled in the output register.
// The next request is accepted while the previous result still waits in the output register.
// Configuration is written through a port that is always ready; the user must write it
// only while no request is active, as the block itself does not enforce this.
`default_nettype none

module transaction_slot_allocator
	import tsa_pkg::*;
#(
	parameter int SLOTS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic        mode,
	input  wire logic [7:0]  invoke_id,
	// result channel
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic [7:0]       assigned_id,
	output logic [2:0]       slot_index,
	output logic             hit,
	output logic [3:0]       idle_count,
	output logic             available,
	// configuration channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data
);

	tsa_cmd_t    cmd;
	tsa_status_t status;

	assign cfg_ready = 1'b1;

	tsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.status   (status),
		.cmd      (cmd)
	);

	tsa_datapath #(
		.SLOTS(SLOTS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode       (mode),
		.invoke_id  (invoke_id),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.status     (status),
		.res_stall  (res_stall),
		.res_valid  (res_valid),
		.assigned_id(assigned_id),
		.slot_index (slot_index),
		.hit        (hit),
		.idle_count (idle_count),
		.available  (available)
	);

endmodule

`default_nettype wire

// File: rtl/tsa_checker.sv
// Port-level checks for the transaction slot allocator, bound to the top level.
// Depends only on the ports of transaction_slot_allocator.
`default_nettype none

module tsa_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       res_valid,
	input wire logic       res_stall,
	input wire logic [7:0] assigned_id,
	input wire logic [2:0] slot_index,
	input wire logic       hit,
	input wire logic [3:0] idle_count,
	input wire logic       available
);

	// a stalled result stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result dropped while stalled");

	// a miss carries no ID and slot zero
	a_miss_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !hit |-> (assigned_id == 8'd0) && (slot_index == 3'd0))
		else $error("miss with nonzero ID or slot");

	// an ID is only given with a hit
	a_id_hit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (assigned_id != 8'd0) |-> hit)
		else $error("ID given without hit");

	// availability agrees with the idle count
	a_avail: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (available == (idle_count != 4'd0)))
		else $error("available disagrees with idle count");

endmodule

bind transaction_slot_allocator tsa_checker u_tsa_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.assigned_id(assigned_id),
	.slot_index (slot_index),
	.hit        (hit),
	.idle_count (idle_count),
	.available  (available)
);

`default_nettype wire
